// ----- rtl/multichannel_calibrated_moving_average_core_defines.svh -----
// Assertion macros shared by the moving average core.
`ifndef MULTICHANNEL_CALIBRATED_MOVING_AVERAGE_CORE_DEFINES_SVH
`define MULTICHANNEL_CALIBRATED_MOVING_AVERAGE_CORE_DEFINES_SVH

// Check on every clock edge outside reset.
`define MCMA_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Check on every clock edge, reset included.
`define MCMA_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

// ----- rtl/mcma_pkg.sv -----
// Shared constants, types and structures of the moving average core.
package mcma_pkg;

   localparam int CHANNELS    = 8;
   localparam int WINDOW      = 8;

   localparam int CH_W        = 3;
   localparam int CODE_W      = 16;
   localparam int CODE_MAX    = 32767;
   localparam int DATA_W      = 32;
   localparam int CAL_W       = 64;
   localparam int NUM_REGS    = 8;
   localparam int REG_IDX_W   = $clog2(NUM_REGS);
   localparam int CSR_INDEX_W = 4;
   localparam int REQ_DATA_W  = 24;
   localparam int RSP_DATA_W  = 72;
   localparam int PROD_W      = 48;

   localparam int CH_IDX_W    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int SLOT_W      = (WINDOW > 1) ? $clog2(WINDOW) : 1;
   localparam int REM_W       = SLOT_W;
   localparam int FILL_W      = $clog2(WINDOW + 1);
   localparam int DEPTH       = CHANNELS * WINDOW;
   localparam int ADDR_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int ENTRY_W     = DATA_W + REM_W;

   localparam int RECIP_SHIFT = $clog2(WINDOW);
   localparam int RECIP_W     = DATA_W + 1;
   localparam int RPROD_W     = DATA_W + RECIP_W;
   localparam logic [63:0] RECIP_FULL =
      ((64'd1 << (DATA_W + RECIP_SHIFT)) + 64'(WINDOW) - 64'd1) / 64'(WINDOW);
   localparam logic [RECIP_W-1:0] RECIP_M = RECIP_FULL[RECIP_W-1:0];
   localparam logic [63:0] BIAS_Q_FULL = (64'd1 << (DATA_W - 1)) / 64'(WINDOW);
   localparam logic [63:0] BIAS_R_FULL = (64'd1 << (DATA_W - 1)) % 64'(WINDOW);
   localparam logic [DATA_W-1:0] BIAS_Q = BIAS_Q_FULL[DATA_W-1:0];
   localparam logic [REM_W-1:0]  BIAS_R = BIAS_R_FULL[REM_W-1:0];

   typedef logic [CH_W-1:0]               ch_type;
   typedef logic [CH_IDX_W-1:0]           ch_idx_type;
   typedef logic [SLOT_W-1:0]             slot_type;
   typedef logic [FILL_W-1:0]             fill_type;
   typedef logic [ADDR_W-1:0]             addr_type;
   typedef logic [REM_W-1:0]              rem_type;
   typedef logic signed [DATA_W-1:0]      data_type;
   typedef logic [CSR_INDEX_W-1:0]        csr_index_type;
   typedef logic [CAL_W-1:0]              cal_type;

   typedef struct packed {
      logic          valid;
      csr_index_type index;
      cal_type       data;
   } csr_type;

   typedef struct packed {
      logic       alloc_en;
      ch_idx_type alloc_ch;
      logic       rd_en;
      addr_type   rd_addr;
      logic       commit_en;
   } win_ctrl_type;

   typedef struct packed {
      ch_idx_type ch;
      slot_type   slot;
      addr_type   addr;
      data_type   quot;
      rem_type    rem;
   } entry_type;

endpackage

// ----- rtl/mcma_ram.sv -----
// Generic single write port, single read port RAM with registered read.
module mcma_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                     clock,
   input  logic                                     wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                         wr_data,
   input  logic                                     rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/mcma_calib.sv -----
// Calibration register bank with per-channel gain and offset selection.
module mcma_calib (
   input  logic             clock,
   input  logic             reset,
   input  mcma_pkg::csr_type csr,
   input  mcma_pkg::ch_type  gain_sel,
   input  mcma_pkg::ch_type  offset_sel,
   output mcma_pkg::data_type gain,
   output mcma_pkg::data_type offset
);
   import mcma_pkg::*;

   cal_type cal_ff [NUM_REGS];
   logic    wr_hit;

   assign wr_hit = csr.valid && (csr.index < CSR_INDEX_W'(NUM_REGS));

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_REGS; i++) begin
            cal_ff[i] <= '0;
         end
      end else if (wr_hit) begin
         cal_ff[csr.index[REG_IDX_W-1:0]] <= csr.data;
      end
   end

   assign gain   = $signed(cal_ff[gain_sel][CAL_W-1:DATA_W]);
   assign offset = $signed(cal_ff[offset_sel][DATA_W-1:0]);

endmodule

// ----- rtl/mcma_recip.sv -----
// Floor division of a calibrated value by the window length via reciprocal product.
module mcma_recip (
   input  mcma_pkg::data_type          value,
   input  logic [mcma_pkg::RPROD_W-1:0] prod,
   output mcma_pkg::data_type          quot,
   output mcma_pkg::rem_type           rem
);
   import mcma_pkg::*;

   logic [DATA_W-1:0]  u;
   logic [RPROD_W-1:0] q_wide;
   logic [DATA_W-1:0]  qu;
   logic [DATA_W-1:0]  back;
   logic [DATA_W-1:0]  ru_full;
   rem_type            ru;
   logic               borrow;
   logic [REM_W:0]     r_sum;
   logic [DATA_W:0]    q_sum;

   always_comb begin
      u       = {~value[DATA_W-1], value[DATA_W-2:0]};
      q_wide  = prod >> (DATA_W + RECIP_SHIFT);
      qu      = q_wide[DATA_W-1:0];
      back    = qu * DATA_W'(WINDOW);
      ru_full = u - back;
      ru      = ru_full[REM_W-1:0];
      borrow  = ru < BIAS_R;
      r_sum   = {1'b0, ru} - {1'b0, BIAS_R} + (borrow ? (REM_W + 1)'(WINDOW) : '0);
      q_sum   = {1'b0, qu} - {1'b0, BIAS_Q} - (DATA_W + 1)'(borrow);
      quot    = $signed(q_sum[DATA_W-1:0]);
      rem     = r_sum[REM_W-1:0];
   end

endmodule

// ----- rtl/mcma_window.sv -----
// Per-channel window store, running quotient and remainder, and mean output.
`include "multichannel_calibrated_moving_average_core_defines.svh"
module mcma_window (
   input  logic                   clock,
   input  logic                   reset,
   input  mcma_pkg::win_ctrl_type ctrl,
   input  mcma_pkg::entry_type    cur,
   output mcma_pkg::slot_type     alloc_slot,
   output mcma_pkg::data_type     mean
);
   import mcma_pkg::*;

   slot_type  slot_ff  [CHANNELS];
   fill_type  fill_ff  [CHANNELS];
   data_type  quot_ff  [CHANNELS];
   rem_type   rem_ff   [CHANNELS];
   logic      fwd_ff;
   logic [ENTRY_W-1:0] fwd_data_ff;

   slot_type  slot_in;
   fill_type  fill_in;
   logic      fwd_in;
   logic [ENTRY_W-1:0] wr_data;
   logic [ENTRY_W-1:0] rd_data;
   logic [ENTRY_W-1:0] old_entry;
   logic      old_valid;
   data_type  old_quot;
   rem_type   old_rem;
   logic signed [DATA_W+1:0] sum_q;
   logic signed [DATA_W+1:0] norm_q;
   logic signed [REM_W+1:0]  sum_r;
   logic signed [REM_W+1:0]  norm_r;
   data_type  quot_new;
   rem_type   rem_new;

   localparam logic signed [REM_W+1:0] WIN_S = (REM_W + 2)'(WINDOW);

   assign alloc_slot = slot_ff[ctrl.alloc_ch];
   assign slot_in    = (alloc_slot == SLOT_W'(WINDOW - 1)) ? '0 : alloc_slot + 1'b1;
   assign fill_in    = (fill_ff[cur.ch] == FILL_W'(WINDOW)) ? fill_ff[cur.ch]
                                                            : fill_ff[cur.ch] + 1'b1;
   assign wr_data    = {cur.quot, cur.rem};
   assign fwd_in     = ctrl.commit_en && (ctrl.rd_addr == cur.addr);

   mcma_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (ctrl.commit_en),
      .wr_addr (cur.addr),
      .wr_data (wr_data),
      .rd_en   (ctrl.rd_en),
      .rd_addr (ctrl.rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      old_entry = fwd_ff ? fwd_data_ff : rd_data;
      old_valid = FILL_W'(cur.slot) < fill_ff[cur.ch];
      old_quot  = old_valid ? $signed(old_entry[ENTRY_W-1:REM_W]) : '0;
      old_rem   = old_valid ? old_entry[REM_W-1:0] : '0;
      sum_q     = (DATA_W + 2)'(quot_ff[cur.ch]) - (DATA_W + 2)'(old_quot)
                + (DATA_W + 2)'(cur.quot);
      sum_r     = $signed({2'b00, rem_ff[cur.ch]}) - $signed({2'b00, old_rem})
                + $signed({2'b00, cur.rem});
      priority if (sum_r < 0) begin
         norm_r = sum_r + WIN_S;
         norm_q = sum_q - 1;
      end else if (sum_r >= WIN_S) begin
         norm_r = sum_r - WIN_S;
         norm_q = sum_q + 1;
      end else begin
         norm_r = sum_r;
         norm_q = sum_q;
      end
      quot_new = $signed(norm_q[DATA_W-1:0]);
      rem_new  = norm_r[REM_W-1:0];
      mean     = quot_new + DATA_W'(quot_new[DATA_W-1] && (rem_new != '0));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < CHANNELS; i++) begin
            slot_ff[i] <= '0;
            fill_ff[i] <= '0;
            quot_ff[i] <= '0;
            rem_ff[i]  <= '0;
         end
         fwd_ff <= 1'b0;
      end else begin
         if (ctrl.alloc_en) begin
            slot_ff[ctrl.alloc_ch] <= slot_in;
         end
         if (ctrl.commit_en) begin
            fill_ff[cur.ch] <= fill_in;
            quot_ff[cur.ch] <= quot_new;
            rem_ff[cur.ch]  <= rem_new;
         end
         if (ctrl.rd_en) begin
            fwd_ff <= fwd_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.rd_en) begin
         fwd_data_ff <= wr_data;
      end
   end

   `MCMA_ASSERT(a_rem_in_range, ctrl.commit_en |-> ({1'b0, rem_new} < (REM_W + 1)'(WINDOW)), "remainder out of range")
   `MCMA_ASSERT(a_fwd_after_commit, $rose(fwd_ff) |-> $past(ctrl.commit_en && ctrl.rd_en), "forward without write")

endmodule

// ----- rtl/multichannel_calibrated_moving_average_core.sv -----
// Top level of the per-channel calibrated moving average core.
// Accepts one request per clock cycle, back to back, on any mix of channels, as long as results
// are taken on the result side; each request with a channel below CHANNELS gives one result through
// four register stages (multiply, saturate and reciprocal product, window division, window update),
// and a request for a higher channel is dropped.
// The rate is set by the window RAM, which takes one read and one write per cycle; a
// back-to-back hit on the entry just written is forwarded. Each channel keeps its window sum
// as a quotient and remainder by WINDOW, so the mean, rounded toward zero, is ready with the
// new value. Window entries not yet written since reset are tracked by a per-channel fill
// count and read as zero; no clearing pass runs.
// Calibration writes are taken at any time but only while the core is idle take clean effect.
`include "multichannel_calibrated_moving_average_core_defines.svh"
module multichannel_calibrated_moving_average_core (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [mcma_pkg::REQ_DATA_W-1:0]   req_tdata,  // channel, raw_code
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [mcma_pkg::RSP_DATA_W-1:0]   rsp_tdata,  // out_channel, pressure, mean_pressure
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  mcma_pkg::csr_index_type           csr_index,
   input  mcma_pkg::cal_type                 csr_data
);
   import mcma_pkg::*;

   localparam logic [CH_W:0] CH_LIMIT = (CH_W + 1)'(CHANNELS);

   ch_type                 req_ch;
   logic [CODE_W-1:0]      req_raw;
   logic [CODE_W-2:0]      code_eff;
   logic                   ch_ok;
   logic                   accept;
   csr_type                csr;
   data_type               gain;
   data_type               offset;
   win_ctrl_type           win_ctrl;
   entry_type              cur;
   slot_type               alloc_slot;
   data_type               mean;

   logic                   p1_valid_ff, p2_valid_ff, p3_valid_ff, rsp_valid_ff;
   ch_type                 p1_ch_ff, p2_ch_ff, p3_ch_ff;
   slot_type               p1_slot_ff, p2_slot_ff, p3_slot_ff;
   addr_type               p1_addr_ff, p2_addr_ff, p3_addr_ff;
   logic signed [PROD_W-1:0] p1_prod_ff;
   logic signed [PROD_W-1:0] p1_prod_in;
   data_type               p2_value_ff, p3_value_ff;
   data_type               p2_value_in;
   logic [RPROD_W-1:0]     p2_prod_ff;
   logic [RPROD_W-1:0]     p2_prod_in;
   data_type               p3_quot_ff;
   data_type               p3_quot_in;
   rem_type                p3_rem_ff;
   rem_type                p3_rem_in;
   addr_type               p1_addr_in;
   logic [RSP_DATA_W-1:0]  rsp_data_ff;
   logic [RSP_DATA_W-1:0]  rsp_data_in;
   logic signed [PROD_W:0] cal_sum;
   logic                   cal_ovf;
   logic [DATA_W-1:0]      p2_u;

   logic                   out_free, p3_free, p2_free, p1_free;
   logic                   adv1, adv2, adv3;
   logic                   pipe_busy;

   assign req_ch   = req_tdata[CH_W-1:0];
   assign req_raw  = req_tdata[CH_W+CODE_W-1:CH_W];
   assign code_eff = (req_raw > CODE_W'(CODE_MAX)) ? '0 : req_raw[CODE_W-2:0];
   assign ch_ok    = {1'b0, req_ch} < CH_LIMIT;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign p3_free    = !p3_valid_ff || out_free;
   assign p2_free    = !p2_valid_ff || p3_free;
   assign p1_free    = !p1_valid_ff || p2_free;
   assign adv3       = p3_valid_ff && out_free;
   assign adv2       = p2_valid_ff && p3_free;
   assign adv1       = p1_valid_ff && p2_free;
   assign req_tready = p1_free;
   assign accept     = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;
   assign pipe_busy  = p1_valid_ff || p2_valid_ff || p3_valid_ff || rsp_valid_ff;

   assign csr.valid = csr_valid;
   assign csr.index = csr_index;
   assign csr.data  = csr_data;

   mcma_calib u_calib (
      .clock      (clock),
      .reset      (reset),
      .csr        (csr),
      .gain_sel   (req_ch),
      .offset_sel (p1_ch_ff),
      .gain       (gain),
      .offset     (offset)
   );

   assign win_ctrl.alloc_en  = accept && ch_ok;
   assign win_ctrl.alloc_ch  = req_ch[CH_IDX_W-1:0];
   assign win_ctrl.rd_en     = adv2;
   assign win_ctrl.rd_addr   = p2_addr_ff;
   assign win_ctrl.commit_en = adv3;

   assign cur.ch   = p3_ch_ff[CH_IDX_W-1:0];
   assign cur.slot = p3_slot_ff;
   assign cur.addr = p3_addr_ff;
   assign cur.quot = p3_quot_ff;
   assign cur.rem  = p3_rem_ff;

   mcma_window u_window (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (win_ctrl),
      .cur        (cur),
      .alloc_slot (alloc_slot),
      .mean       (mean)
   );

   mcma_recip u_recip (
      .value (p2_value_ff),
      .prod  (p2_prod_ff),
      .quot  (p3_quot_in),
      .rem   (p3_rem_in)
   );

   always_comb begin
      p1_prod_in  = $signed({1'b0, code_eff}) * gain;
      p1_addr_in  = ADDR_W'(req_ch[CH_IDX_W-1:0]) * ADDR_W'(WINDOW) + ADDR_W'(alloc_slot);
      cal_sum     = (PROD_W + 1)'(p1_prod_ff) + (PROD_W + 1)'(offset);
      cal_ovf     = cal_sum[PROD_W:DATA_W-1] != {(PROD_W - DATA_W + 2){cal_sum[PROD_W]}};
      if (cal_ovf) begin
         p2_value_in = cal_sum[PROD_W] ? {1'b1, {(DATA_W - 1){1'b0}}}
                                       : {1'b0, {(DATA_W - 1){1'b1}}};
      end else begin
         p2_value_in = $signed(cal_sum[DATA_W-1:0]);
      end
      p2_u        = {~p2_value_in[DATA_W-1], p2_value_in[DATA_W-2:0]};
      p2_prod_in  = p2_u * RECIP_M;
      rsp_data_in = {(RSP_DATA_W - CH_W - 2 * DATA_W)'(0), mean, p3_value_ff, p3_ch_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_valid_ff  <= 1'b0;
         p2_valid_ff  <= 1'b0;
         p3_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (p1_free) begin
            p1_valid_ff <= accept && ch_ok;
         end
         if (p2_free) begin
            p2_valid_ff <= adv1;
         end
         if (p3_free) begin
            p3_valid_ff <= adv2;
         end
         if (out_free) begin
            rsp_valid_ff <= adv3;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         p1_ch_ff   <= req_ch;
         p1_slot_ff <= alloc_slot;
         p1_addr_ff <= p1_addr_in;
         p1_prod_ff <= p1_prod_in;
      end
      if (adv1) begin
         p2_ch_ff    <= p1_ch_ff;
         p2_slot_ff  <= p1_slot_ff;
         p2_addr_ff  <= p1_addr_ff;
         p2_value_ff <= p2_value_in;
         p2_prod_ff  <= p2_prod_in;
      end
      if (adv2) begin
         p3_ch_ff    <= p2_ch_ff;
         p3_slot_ff  <= p2_slot_ff;
         p3_addr_ff  <= p2_addr_ff;
         p3_value_ff <= p2_value_ff;
         p3_quot_ff  <= p3_quot_in;
         p3_rem_ff   <= p3_rem_in;
      end
      if (adv3) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   `MCMA_ASSERT(a_accept_loads_p1, (accept && ch_ok) |=> p1_valid_ff, "accepted request lost")
   `MCMA_ASSERT(a_rsp_from_p3, $rose(rsp_valid_ff) |-> $past(p3_valid_ff), "result without source")
   `MCMA_ASSERT_ALWAYS(a_reset_empty, reset |=> !pipe_busy, "pipeline not empty after reset")

endmodule
